@@ hw/rtl/trm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the tile rotation address mapper.
// ----------------------------------------------------------------------------
package trm_pkg;

  // Coordinate and register widths
  localparam int unsigned MAX_FRAME_SIDE = 2048;
  localparam int unsigned CW             = $clog2(MAX_FRAME_SIDE);
  localparam int unsigned FRAME_W        = 12;
  localparam int unsigned SHIFT_W        = 3;
  localparam int unsigned MAX_SHIFT      = 5;
  localparam int unsigned LOC_W          = MAX_SHIFT;
  localparam int unsigned TILE_IDX_W     = 14;
  localparam int unsigned DIR_W          = 2;
  localparam int unsigned TIDX_W         = 24;

  // Defaults of the top-level parameters
  localparam int unsigned MAP_ENTRIES_DEF = 16384;
  localparam int unsigned PIXEL_BITS_DEF  = 32;

  // Register reset values
  localparam logic [SHIFT_W-1:0] TILE_SHIFT_RST   = SHIFT_W'(4);
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(640);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(480);

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_TILE_SHIFT   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_idx_e;

  // Tile turn codes
  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  // Item kinds carried on tuser
  localparam logic ACT_MAP_WRITE = 1'b0;
  localparam logic ACT_PIXEL     = 1'b1;

  // Direction map port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

endpackage

@@ hw/rtl/trm_dir_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_dir_map
// Direction map store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module trm_dir_map #(
  parameter int unsigned DEPTH = trm_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(trm_pkg::MAP_ENTRIES_DEF)
) (
  input  logic              clk_i,
  input  trm_pkg::map_ctl_t ctl_i,
  input  logic [AW-1:0]     addr_i,
  input  trm_pkg::dir_e     wdata_i,
  output trm_pkg::dir_e     rdata_o
);
  import trm_pkg::*;

  logic [DIR_W-1:0] mem_q [DEPTH];
  logic [DIR_W-1:0] rd_q;

  // Write a map entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read a map entry, hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = dir_e'(rd_q);

endmodule

@@ hw/rtl/tile_rotation_address_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_rotation_address_mapper
// Turns each whole square tile of a frame by 0, 90, 180 or 270 degrees.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser[0] selects the kind: 0 loads one entry of
//   the direction map (tile_index, direction), 1 maps a pixel (src_x, src_y,
//   pixel). Every request gives exactly one response on m_axis: for a pixel
//   in a whole tile the destination coordinate and the pixel with tuser[0]
//   (written) set; for a map load or a pixel outside whole tiles all zeros.
//   One request is taken every cycle while the output is not stalled. The
//   per-pixel path is split over four register stages: tile split, tile
//   index multiply-add, map memory read (single port, at most one access
//   per request) and remap into the output register.
//   Reset empties the pipeline and loads tile_shift 4, frame 640 x 480; the
//   direction map is not cleared and must be loaded before use.
//   When m_axis_tready is low with a response waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
//   Registers (APB, byte address 4*i): tile_shift, frame_width, frame_height;
//   write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tile_rotation_address_mapper #(
  parameter int unsigned MAP_ENTRIES = trm_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned PIXEL_BITS  = trm_pkg::PIXEL_BITS_DEF,
  parameter int unsigned IN_TDATA_W  =
    ((2 * trm_pkg::CW + trm_pkg::TILE_IDX_W + trm_pkg::DIR_W + PIXEL_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_TDATA_W =
    ((2 * trm_pkg::CW + PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tile_index, direction, src_x, src_y, pixel (from bit 0 up), zero padded
  input  logic [IN_TDATA_W-1:0]       s_axis_tdata,
  // action
  input  logic [0:0]                  s_axis_tuser,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // dest_x, dest_y, pixel_out (from bit 0 up), zero padded
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // written
  output logic [0:0]                  m_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trm_pkg::PADDR_W-1:0] paddr,
  input  logic [trm_pkg::PDATA_W-1:0] pwdata,
  output logic [trm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import trm_pkg::*;

  localparam int unsigned MAP_AW  = $clog2(MAP_ENTRIES);
  // input field offsets
  localparam int unsigned IDX_LO  = 0;
  localparam int unsigned DIR_LO  = IDX_LO + TILE_IDX_W;
  localparam int unsigned SX_LO   = DIR_LO + DIR_W;
  localparam int unsigned SY_LO   = SX_LO + CW;
  localparam int unsigned PIX_LO  = SY_LO + CW;
  // output field offsets
  localparam int unsigned PO_LO   = 2 * CW;
  localparam int unsigned OUT_PAD = OUT_TDATA_W - PO_LO - PIXEL_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SHIFT_W-1:0] tile_shift_q, tile_shift_d;
  logic [FRAME_W-1:0] frame_width_q, frame_width_d;
  logic [FRAME_W-1:0] frame_height_q, frame_height_d;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  // Decode a register write, saturate the tile shift
  always_comb begin
    tile_shift_d   = tile_shift_q;
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we) begin
      case (cfg_idx)
        REG_TILE_SHIFT: begin
          tile_shift_d = (pwdata[SHIFT_W-1:0] > SHIFT_W'(MAX_SHIFT)) ?
                         SHIFT_W'(MAX_SHIFT) : pwdata[SHIFT_W-1:0];
        end
        REG_FRAME_WIDTH:  frame_width_d  = pwdata[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height_d = pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_shift_q   <= TILE_SHIFT_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else begin
      tile_shift_q   <= tile_shift_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Register read back
  always_comb begin
    case (cfg_idx)
      REG_TILE_SHIFT:   prdata = PDATA_W'(tile_shift_q);
      REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together
  // --------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic v1_q, v2_q, v3_q, vo_q;

  assign advance       = !vo_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_acc        = s_axis_tvalid && advance;
  assign m_axis_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Tile side minus one, from the current shift
  logic [LOC_W:0]   side_full;
  logic [LOC_W-1:0] side_m1;

  assign side_full = (LOC_W + 1)'(1) << tile_shift_q;
  assign side_m1   = LOC_W'(side_full - (LOC_W + 1)'(1));

  // --------------------------------------------------------------------------
  // Stage 1: split the coordinate into tile and local offset
  // --------------------------------------------------------------------------
  logic [CW-1:0]         in_x, in_y;
  logic [CW-1:0]         tx_c, ty_c;
  logic [FRAME_W-1:0]    map_w_c, map_h_c;
  logic                  inside_c;

  logic                  act1_q, inside1_q;
  logic [CW-1:0]         tx1_q, ty1_q, bx1_q, by1_q;
  logic [FRAME_W-1:0]    map_w1_q;
  logic [LOC_W-1:0]      lx1_q, ly1_q;
  logic [TILE_IDX_W-1:0] widx1_q;
  dir_e                  wdir1_q;
  logic [PIXEL_BITS-1:0] pix1_q;

  assign in_x     = s_axis_tdata[SX_LO +: CW];
  assign in_y     = s_axis_tdata[SY_LO +: CW];
  assign tx_c     = in_x >> tile_shift_q;
  assign ty_c     = in_y >> tile_shift_q;
  assign map_w_c  = frame_width_q >> tile_shift_q;
  assign map_h_c  = frame_height_q >> tile_shift_q;
  assign inside_c = (FRAME_W'(tx_c) < map_w_c) && (FRAME_W'(ty_c) < map_h_c);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act1_q    <= s_axis_tuser[0];
      inside1_q <= inside_c;
      tx1_q     <= tx_c;
      ty1_q     <= ty_c;
      bx1_q     <= in_x & ~CW'(side_m1);
      by1_q     <= in_y & ~CW'(side_m1);
      map_w1_q  <= map_w_c;
      lx1_q     <= in_x[LOC_W-1:0] & side_m1;
      ly1_q     <= in_y[LOC_W-1:0] & side_m1;
      widx1_q   <= s_axis_tdata[IDX_LO +: TILE_IDX_W];
      wdir1_q   <= dir_e'(s_axis_tdata[DIR_LO +: DIR_W]);
      pix1_q    <= s_axis_tdata[PIX_LO +: PIXEL_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: row-major tile index, pick the map address
  // --------------------------------------------------------------------------
  logic [TIDX_W-1:0]     tidx_c, addr_c;
  logic                  in_map_c;

  logic                  act2_q, inside2_q, in_map2_q;
  map_ctl_t              ctl2_q;
  logic [MAP_AW-1:0]     addr2_q;
  dir_e                  wdir2_q;
  logic [CW-1:0]         bx2_q, by2_q;
  logic [LOC_W-1:0]      lx2_q, ly2_q;
  logic [PIXEL_BITS-1:0] pix2_q;

  assign tidx_c   = TIDX_W'(ty1_q) * TIDX_W'(map_w1_q) + TIDX_W'(tx1_q);
  assign addr_c   = (act1_q == ACT_PIXEL) ? tidx_c : TIDX_W'(widx1_q);
  assign in_map_c = addr_c < TIDX_W'(MAP_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act2_q       <= act1_q;
      inside2_q    <= inside1_q;
      in_map2_q    <= in_map_c;
      ctl2_q.rd_en <= v1_q && (act1_q == ACT_PIXEL) && inside1_q && in_map_c;
      ctl2_q.wr_en <= v1_q && (act1_q == ACT_MAP_WRITE) && in_map_c;
      addr2_q      <= addr_c[MAP_AW-1:0];
      wdir2_q      <= wdir1_q;
      bx2_q        <= bx1_q;
      by2_q        <= by1_q;
      lx2_q        <= lx1_q;
      ly2_q        <= ly1_q;
      pix2_q       <= pix1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: direction map access
  // --------------------------------------------------------------------------
  map_ctl_t              map_ctl;
  dir_e                  map_dir;

  logic                  wr3_q, rot3_q;
  logic [CW-1:0]         bx3_q, by3_q;
  logic [LOC_W-1:0]      lx3_q, ly3_q;
  logic [PIXEL_BITS-1:0] pix3_q;

  assign map_ctl.rd_en = advance && ctl2_q.rd_en;
  assign map_ctl.wr_en = advance && ctl2_q.wr_en;

  trm_dir_map #(
    .DEPTH (MAP_ENTRIES),
    .AW    (MAP_AW)
  ) u_dir_map (
    .clk_i   (clk_i),
    .ctl_i   (map_ctl),
    .addr_i  (addr2_q),
    .wdata_i (wdir2_q),
    .rdata_o (map_dir)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      wr3_q  <= (act2_q == ACT_PIXEL) && inside2_q;
      rot3_q <= in_map2_q;
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;
      lx3_q  <= lx2_q;
      ly3_q  <= ly2_q;
      pix3_q <= pix2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: turn the local offset, output register
  // --------------------------------------------------------------------------
  dir_e                  dir_c;
  logic [LOC_W-1:0]      nx_c, ny_c;

  logic [CW-1:0]         dx_q, dy_q;
  logic [PIXEL_BITS-1:0] po_q;
  logic                  wro_q;

  // Tiles beyond the map store stay unrotated
  assign dir_c = rot3_q ? map_dir : DIR_UP;

  always_comb begin
    case (dir_c)
      DIR_LEFT: begin
        nx_c = side_m1 - ly3_q;
        ny_c = lx3_q;
      end
      DIR_DOWN: begin
        nx_c = side_m1 - lx3_q;
        ny_c = side_m1 - ly3_q;
      end
      DIR_RIGHT: begin
        nx_c = ly3_q;
        ny_c = side_m1 - lx3_q;
      end
      default: begin
        nx_c = lx3_q;
        ny_c = ly3_q;
      end
    endcase
  end

  // Zero everything that is not a written pixel
  always_ff @(posedge clk_i) begin
    if (advance) begin
      wro_q <= wr3_q;
      dx_q  <= wr3_q ? (bx3_q | CW'(nx_c)) : '0;
      dy_q  <= wr3_q ? (by3_q | CW'(ny_c)) : '0;
      po_q  <= wr3_q ? pix3_q : '0;
    end
  end

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, po_q, dy_q, dx_q};
  assign m_axis_tuser = wro_q;

endmodule
